// ----- rtl/tpft_pkg.sv -----
// ----------------------------------------------------------------------------
// tpft_pkg
// Shared types and constants for the text packet field tokenizer: byte
// codes of the delimiters, field kind and closure codes, and the tag that
// the parser hands to the output stage.
// ----------------------------------------------------------------------------
package tpft_pkg;

  // Delimiter bytes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;

  // Field kind reported with each byte
  typedef enum logic [2:0] {
    KIND_CMD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_KEY   = 3'd2,
    KIND_VAL   = 3'd3,
    KIND_BODY  = 3'd4,
    KIND_DELIM = 3'd5,
    KIND_DROP  = 3'd6
  } kind_t;

  // Field closed by this byte
  typedef enum logic [2:0] {
    CLOSE_NONE = 3'd0,
    CLOSE_CMD  = 3'd1,
    CLOSE_SUB  = 3'd2,
    CLOSE_PAIR = 3'd3,
    CLOSE_DISC = 3'd4
  } close_t;

  // Tag produced by the parser for one byte
  typedef struct packed {
    kind_t  kind;
    close_t closed;
  } tag_t;

endpackage

// ----- rtl/tpft_parser.sv -----
// ----------------------------------------------------------------------------
// tpft_parser
// Parse state machine. Tags the byte at its input and, when step is high,
// advances the phase and the first-pair flag for that byte.
// ----------------------------------------------------------------------------
module tpft_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_in,
  input  logic              end_of_packet,
  input  logic              skip_after_first_pair,
  output tpft_pkg::tag_t    tag
);
  import tpft_pkg::*;

  typedef enum logic [2:0] {
    PH_CMD  = 3'd0,
    PH_SUB  = 3'd1,
    PH_LINE = 3'd2,
    PH_KEY  = 3'd3,
    PH_VAL  = 3'd4,
    PH_DROP = 3'd5,
    PH_BODY = 3'd6
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   pending_r, pending_nxt;

  kind_t  kind;
  close_t closed;
  close_t end_close;
  logic   delim;
  logic   is_nl, is_sp, is_eq;
  phase_t line_next;
  logic   line_clears;

  assign is_nl = (char_in == CH_NEWLINE);
  assign is_sp = (char_in == CH_SPACE);
  assign is_eq = (char_in == CH_EQUALS);

  // Phase after a key or key=value line ends; drop one byte after the first one when skip is set
  assign line_next   = (pending_r && skip_after_first_pair) ? PH_DROP : PH_LINE;
  assign line_clears = pending_r;

  // Tag the byte and pick the next phase
  always_comb begin
    kind        = KIND_BODY;
    closed      = CLOSE_NONE;
    end_close   = CLOSE_NONE;
    delim       = 1'b0;
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    unique case (phase_r)
      PH_CMD: begin
        if (is_sp || is_nl) begin
          kind      = KIND_DELIM;
          closed    = CLOSE_CMD;
          delim     = 1'b1;
          phase_nxt = is_sp ? PH_SUB : PH_BODY;
        end else begin
          kind      = KIND_CMD;
          end_close = CLOSE_CMD;
        end
      end
      PH_SUB: begin
        if (is_nl) begin
          kind      = KIND_DELIM;
          closed    = CLOSE_SUB;
          delim     = 1'b1;
          phase_nxt = PH_LINE;
        end else begin
          kind      = KIND_SUB;
          end_close = CLOSE_SUB;
        end
      end
      PH_LINE: begin
        if (is_nl) begin
          kind      = KIND_DELIM;
          delim     = 1'b1;
          phase_nxt = PH_BODY;
        end else if (is_eq) begin
          kind      = KIND_DELIM;
          end_close = CLOSE_PAIR;
          phase_nxt = PH_VAL;
        end else begin
          kind      = KIND_KEY;
          end_close = CLOSE_DISC;
          phase_nxt = PH_KEY;
        end
      end
      PH_KEY: begin
        if (is_nl) begin
          kind      = KIND_DELIM;
          closed    = CLOSE_DISC;
          delim     = 1'b1;
          phase_nxt = line_next;
          if (line_clears) begin
            pending_nxt = 1'b0;
          end
        end else if (is_eq) begin
          kind      = KIND_DELIM;
          end_close = CLOSE_PAIR;
          phase_nxt = PH_VAL;
        end else begin
          kind      = KIND_KEY;
          end_close = CLOSE_DISC;
        end
      end
      PH_VAL: begin
        if (is_nl) begin
          kind      = KIND_DELIM;
          closed    = CLOSE_PAIR;
          delim     = 1'b1;
          phase_nxt = line_next;
          if (line_clears) begin
            pending_nxt = 1'b0;
          end
        end else begin
          kind      = KIND_VAL;
          end_close = CLOSE_PAIR;
        end
      end
      PH_DROP: begin
        kind      = KIND_DROP;
        phase_nxt = PH_LINE;
      end
      default: begin
        kind      = KIND_BODY;
        phase_nxt = PH_BODY;
      end
    endcase

    // Close the open field at the end of the packet and restart
    if (end_of_packet) begin
      if (!delim) begin
        closed = end_close;
      end
      phase_nxt   = PH_CMD;
      pending_nxt = 1'b1;
    end
  end

  assign tag.kind   = kind;
  assign tag.closed = closed;

  // Hold the parse state; advance once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CMD;
      pending_r <= 1'b1;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

// ----- rtl/text_packet_field_tokenizer.sv -----
// ----------------------------------------------------------------------------
// text_packet_field_tokenizer
// Tags each byte of a text packet with its field and reports the field
// that each delimiter closes.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   in_char_in, in_end_of_packet
//   out      out_valid / out_ready out_char_out, out_field_kind,
//                                  out_field_closed, out_packet_done
//   cfg      cfg_wr_en             cfg_wr_data (skip after first pair)
//
// One request per cycle sustained while out is not stalled; each byte's result
// passes through the input register, then the result register, from which it
// is presented on out until taken.
// The parser advances when a byte moves from the input register into the
// result register. A stall on out holds the result register and the parser
// state; the input register still takes one request and then holds too.
// rst_n is synchronous: it empties both stages and returns the parser to
// the command phase with the skip register cleared.
// ----------------------------------------------------------------------------
module text_packet_field_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_packet,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic [2:0] out_field_kind,
  output logic [2:0] out_field_closed,
  output logic       out_packet_done,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import tpft_pkg::*;

  logic       skip_r;
  logic       in_vld_r;
  logic [7:0] in_char_r;
  logic       in_eop_r;
  logic       out_vld_r;
  logic [7:0] out_char_r;
  logic [2:0] out_kind_r;
  logic [2:0] out_closed_r;
  logic       out_done_r;
  logic       advance;
  logic       step;
  tag_t       tag;

  // Result register frees when empty or taken; input register behind it
  assign advance  = !out_vld_r || out_ready;
  assign step     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  tpft_parser u_parser (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .step                  (step),
    .char_in               (in_char_r),
    .end_of_packet         (in_eop_r),
    .skip_after_first_pair (skip_r),
    .tag                   (tag)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
    end else if (cfg_wr_en) begin
      skip_r <= cfg_wr_data;
    end
  end

  // Input register: load on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_in;
      in_eop_r  <= in_end_of_packet;
    end
  end

  // Result register: load the tagged byte, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_char_r   <= in_char_r;
      out_kind_r   <= tag.kind;
      out_closed_r <= tag.closed;
      out_done_r   <= in_eop_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_char_out     = out_char_r;
  assign out_field_kind   = out_kind_r;
  assign out_field_closed = out_closed_r;
  assign out_packet_done  = out_done_r;

endmodule
